[hdl/window_limit_safety_monitor_macros.svh]
// ----------------------------------------------------------------------------
// Window limit safety monitor: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WINDOW_LIMIT_SAFETY_MONITOR_MACROS_SVH
`define WINDOW_LIMIT_SAFETY_MONITOR_MACROS_SVH

// Same-cycle implication.
`define WLSM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define WLSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/wlsm_pkg.sv]
// ----------------------------------------------------------------------------
// Window limit safety monitor package
// Item types, limit and state records, operation, level and reason codes.
// ----------------------------------------------------------------------------
package wlsm_pkg;

	localparam int unsigned FAULT_LIMIT = 3;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// operation codes
	localparam logic [1:0] OP_CHECK = 2'd0;
	localparam logic [1:0] OP_ACK   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// safety levels
	localparam logic [1:0] LVL_NORMAL = 2'd0;
	localparam logic [1:0] LVL_WARN   = 2'd1;
	localparam logic [1:0] LVL_ALARM  = 2'd2;
	localparam logic [1:0] LVL_ESTOP  = 2'd3;

	// reason codes
	localparam logic [3:0] RSN_NONE      = 4'd0;
	localparam logic [3:0] RSN_PH_LOW    = 4'd1;
	localparam logic [3:0] RSN_PH_HIGH   = 4'd2;
	localparam logic [3:0] RSN_PH_WARN   = 4'd3;
	localparam logic [3:0] RSN_TDS_LOW   = 4'd4;
	localparam logic [3:0] RSN_TDS_HIGH  = 4'd5;
	localparam logic [3:0] RSN_TEMP      = 4'd6;
	localparam logic [3:0] RSN_LVL_LOW   = 4'd7;
	localparam logic [3:0] RSN_LVL_HIGH  = 4'd8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PH_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PH_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TDS_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TDS_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LVL_LOW   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LVL_HIGH  = 3'd7;

	// pH warning band, 0.50 pH in hundredths
	localparam logic [11:0] PH_WARN_MARGIN = 12'd50;

	localparam logic [7:0] FAULT_LIMIT_C = 8'(FAULT_LIMIT);

	typedef struct packed {
		logic [1:0]         operation;
		logic [10:0]        ph_reading;
		logic [15:0]        tds_reading;
		logic signed [11:0] temp_reading;
		logic [9:0]         level_reading;
	} chk_item_t;

	typedef struct packed {
		logic [1:0] safety_level;
		logic [3:0] reason_code;
		logic [7:0] alarm_run;
	} res_item_t;

	typedef struct packed {
		logic [10:0]        ph_low;
		logic [10:0]        ph_high;
		logic [15:0]        tds_low;
		logic [15:0]        tds_high;
		logic signed [11:0] temp_low;
		logic signed [11:0] temp_high;
		logic [9:0]         lvl_low;
		logic [9:0]         lvl_high;
	} limits_t;

	typedef struct packed {
		logic [1:0] level;
		logic [3:0] reason;
		logic [7:0] count;
	} mon_state_t;

endpackage

[hdl/wlsm_eval.sv]
// ----------------------------------------------------------------------------
// Window limit safety monitor: item evaluation
// Window compares, reason priority, alarm run update and acknowledge and clear handling for one item.
// ----------------------------------------------------------------------------
module wlsm_eval (
	input  wlsm_pkg::chk_item_t  item,
	input  wlsm_pkg::limits_t    lim,
	input  wlsm_pkg::mon_state_t cur,
	output wlsm_pkg::mon_state_t nxt
);
	import wlsm_pkg::*;

	logic [11:0] ph_ext;
	logic [11:0] phl_ext;
	logic [11:0] phh_ext;
	logic [1:0]  chk_level;
	logic [3:0]  chk_reason;

	assign ph_ext  = {1'b0, item.ph_reading};
	assign phl_ext = {1'b0, lim.ph_low};
	assign phh_ext = {1'b0, lim.ph_high};

	// findings in check order; later ones override
	always_comb begin
		chk_level  = LVL_NORMAL;
		chk_reason = RSN_NONE;
		if (item.ph_reading < lim.ph_low) begin
			chk_level  = LVL_ALARM;
			chk_reason = RSN_PH_LOW;
		end else if (item.ph_reading > lim.ph_high) begin
			chk_level  = LVL_ALARM;
			chk_reason = RSN_PH_HIGH;
		end else if ((ph_ext < phl_ext + PH_WARN_MARGIN) ||
				(ph_ext + PH_WARN_MARGIN > phh_ext)) begin
			chk_level  = LVL_WARN;
			chk_reason = RSN_PH_WARN;
		end
		if (item.tds_reading < lim.tds_low) begin
			chk_level  = LVL_ALARM;
			chk_reason = RSN_TDS_LOW;
		end else if (item.tds_reading > lim.tds_high) begin
			chk_level  = LVL_ALARM;
			chk_reason = RSN_TDS_HIGH;
		end
		if (($signed(item.temp_reading) < $signed(lim.temp_low)) ||
				($signed(item.temp_reading) > $signed(lim.temp_high))) begin
			chk_level  = LVL_ALARM;
			chk_reason = RSN_TEMP;
		end
		if (item.level_reading < lim.lvl_low) begin
			chk_level  = LVL_ALARM;
			chk_reason = RSN_LVL_LOW;
		end else if (item.level_reading > lim.lvl_high) begin
			// level-high only when nothing else was found
			if (chk_level == LVL_NORMAL) begin
				chk_level  = LVL_WARN;
				chk_reason = RSN_LVL_HIGH;
			end
		end
	end

	always_comb begin
		nxt = cur;
		case (item.operation)
			OP_CHECK: begin
				nxt.reason = chk_reason;
				if (chk_level == LVL_ALARM) begin
					if (cur.count < FAULT_LIMIT_C) begin
						nxt.count = cur.count + 8'd1;
					end
					nxt.level = (nxt.count >= FAULT_LIMIT_C) ? LVL_ESTOP : LVL_ALARM;
				end else begin
					nxt.count = '0;
					nxt.level = chk_level;
				end
			end
			OP_ACK: begin
				if (cur.level == LVL_ALARM) begin
					nxt.level = LVL_WARN;
				end
				nxt.count = '0;
			end
			OP_CLEAR: begin
				nxt.level  = LVL_NORMAL;
				nxt.reason = RSN_NONE;
				nxt.count  = '0;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

[hdl/window_limit_safety_monitor.sv]
// ----------------------------------------------------------------------------
// Window limit safety monitor
// Grades sensor check items against configured window limits, tracks
// alarm runs and handles acknowledge and clear operations.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction | payload
//  chk     | chk_valid, chk_stall, chk_data   | in        | chk_item_t
//  res     | res_valid, res_stall, res_data   | out       | res_item_t
//  cfg     | cfg_valid, cfg_ready, cfg_index  | in        | cfg_data, 16 bit
//
// One item per cycle sustained while res is not stalled; after the chk transfer
// the item passes the input register, then evaluation into the result register.
// Monitor state updates as an item moves from input to result register.
// A stall on res holds the result register and a full input register;
// chk_stall rises only when the input register is full and cannot move.
// cfg_ready is always high.
// Reset loads the default limits and clears level, reason and alarm run.
// ----------------------------------------------------------------------------
`include "window_limit_safety_monitor_macros.svh"

module window_limit_safety_monitor (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   chk_valid,
	output logic                                   chk_stall,
	input  wlsm_pkg::chk_item_t                    chk_data,
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output wlsm_pkg::res_item_t                    res_data,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [wlsm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [wlsm_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import wlsm_pkg::*;

	chk_item_t  item_s1;
	logic       valid_s1;
	logic       res_valid_q;
	res_item_t  res_q;
	limits_t    lim_q;
	mon_state_t state_q;
	mon_state_t state_nxt;
	logic       advance;

	assign cfg_ready = 1'b1;

	assign advance   = !res_valid_q || !res_stall;
	assign chk_stall = valid_s1 && !advance;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	wlsm_eval u_eval (
		.item (item_s1),
		.lim  (lim_q),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q.ph_low    <= 11'd500;
			lim_q.ph_high   <= 11'd750;
			lim_q.tds_low   <= 16'd200;
			lim_q.tds_high  <= 16'd2000;
			lim_q.temp_low  <= 12'sd150;
			lim_q.temp_high <= 12'sd300;
			lim_q.lvl_low   <= 10'd200;
			lim_q.lvl_high  <= 10'd950;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PH_LOW:    lim_q.ph_low    <= cfg_data[10:0];
				REG_PH_HIGH:   lim_q.ph_high   <= cfg_data[10:0];
				REG_TDS_LOW:   lim_q.tds_low   <= cfg_data;
				REG_TDS_HIGH:  lim_q.tds_high  <= cfg_data;
				REG_TEMP_LOW:  lim_q.temp_low  <= $signed(cfg_data[11:0]);
				REG_TEMP_HIGH: lim_q.temp_high <= $signed(cfg_data[11:0]);
				REG_LVL_LOW:   lim_q.lvl_low   <= cfg_data[9:0];
				REG_LVL_HIGH:  lim_q.lvl_high  <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	// input stage; an empty stage loads even while the result is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!chk_stall) begin
			valid_s1 <= chk_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chk_valid && !chk_stall) begin
			item_s1 <= chk_data;
		end
	end

	// monitor state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q.safety_level <= state_nxt.level;
			res_q.reason_code  <= state_nxt.reason;
			res_q.alarm_run    <= state_nxt.count;
		end
	end

	`WLSM_ASSERT_IMP(a_run_bounded, 1'b1, state_q.count <= FAULT_LIMIT_C, "alarm run above limit")
	`WLSM_ASSERT_IMP(a_run_needs_alarm, state_q.count != 8'd0, state_q.level == LVL_ALARM || state_q.level == LVL_ESTOP, "alarm run without alarm level")
	`WLSM_ASSERT_IMP(a_reason_level, state_q.reason == RSN_NONE, state_q.level == LVL_NORMAL, "level set without reason")
	`WLSM_ASSERT_NEXT(a_stage_moves, valid_s1 && advance, res_valid, "item lost between stages")
	`WLSM_ASSERT_IMP(a_empty_no_stall, !valid_s1, !chk_stall, "stall with empty input stage")

endmodule
